@@ rtl/motor_feedback_frame_decoder_unit_defines.svh @@
// Assertion macros for the motor feedback frame decoder checker.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef MOTOR_FEEDBACK_FRAME_DECODER_UNIT_DEFINES_SVH
`define MOTOR_FEEDBACK_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define MFFD_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define MFFD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/mffd_pkg.sv @@
// Shared types, constants and the divide-by-all-ones helper of the frame decoder.
// No dependencies.
package mffd_pkg;

  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned POS_CODE_BITS = 16;
  localparam int unsigned VT_CODE_BITS = 12;

  localparam logic signed [20:0] HALF_TURN = 21'(25 << (FRAC_BITS - 1));
  localparam logic [48:0] FULL_TURN = 49'(25 << FRAC_BITS);
  localparam logic [16:0] CNT_MAX = 17'h1FFFF;

  // Turn count extremes and their scaled images, for the 32-bit wrap of the count.
  localparam logic [31:0] TURNS_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] TURNS_NEG_MIN = 32'h8000_0000;
  localparam logic [48:0] TURN_Q_MAX = 49'(64'h0000_0000_7FFF_FFFF * 64'(FULL_TURN));
  localparam logic [48:0] TURN_Q_MIN = 49'(64'hFFFF_FFFF_8000_0000 * 64'(FULL_TURN));

  localparam logic [18:0] POS_LIMIT_RST = 19'd51200;
  localparam logic [20:0] VEL_LIMIT_RST = 21'd184320;
  localparam logic [20:0] TRQ_LIMIT_RST = 21'd73728;
  localparam logic [15:0] ERR_THR_RST = 16'd1000;
  localparam logic [15:0] SHORT_THR_RST = 16'd1000;
  localparam logic [15:0] LONG_THR_RST = 16'd10000;

  typedef enum logic [1:0] {
    KIND_MEAS    = 2'd0,
    KIND_ENABLE  = 2'd1,
    KIND_CLEAR   = 2'd2,
    KIND_DISABLE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_POS_LIMIT = 3'd0,
    REG_VEL_LIMIT = 3'd1,
    REG_TRQ_LIMIT = 3'd2,
    REG_ERR_THR   = 3'd3,
    REG_SHORT_THR = 3'd4,
    REG_LONG_THR  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [18:0] pos_limit;
    logic [20:0] vel_limit;
    logic [20:0] trq_limit;
    logic [15:0] err_thr;
    logic [15:0] short_thr;
    logic [15:0] long_thr;
  } cfg_t;

  typedef struct packed {
    logic              action;
    logic [3:0]        motor_id;
    logic [3:0]        motor_state;
    logic signed [19:0] position;
    logic signed [21:0] velocity;
    logic signed [21:0] torque;
    logic [7:0]        mos_temperature;
    logic [7:0]        coil_temperature;
  } scaled_t;

  typedef struct packed {
    logic [3:0]         motor_id;
    logic [3:0]         motor_state;
    logic signed [19:0] position;
    logic signed [21:0] velocity;
    logic signed [21:0] torque;
    logic [7:0]         mos_temperature;
    logic [7:0]         coil_temperature;
    logic signed [31:0] turn_count;
    logic signed [48:0] multiturn_position;
    logic               error_latched;
    logic               cmd_enable;
    logic               cmd_clear;
  } rec_t;

  // Rounded quotient (2*prod + half) / (2^bits - 1) without a divider: two folds of
  // the high part onto the low part leave a remainder below twice the divisor.
  function automatic logic [21:0] div_code(input logic [34:0] prod, input int unsigned bits);
    logic [36:0] mask;
    logic [36:0] y;
    logic [36:0] q1;
    logic [36:0] r1;
    logic [36:0] q2;
    logic [36:0] r2;
    logic [36:0] sum;
    mask = (37'd1 << bits) - 37'd1;
    y = {1'b0, prod, 1'b0} + (mask >> 1);
    q1 = y >> bits;
    r1 = (y & mask) + q1;
    q2 = r1 >> bits;
    r2 = (r1 & mask) + q2;
    sum = q1 + q2 + ((r2 >= mask) ? 37'd1 : 37'd0);
    return sum[21:0];
  endfunction

endpackage

@@ rtl/mffd_regs.sv @@
// APB-style configuration registers of the frame decoder.
// Depends on mffd_pkg.
module mffd_regs
  import mffd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_POS_LIMIT: cfg_nxt.pos_limit = pwdata[18:0];
        REG_VEL_LIMIT: cfg_nxt.vel_limit = pwdata[20:0];
        REG_TRQ_LIMIT: cfg_nxt.trq_limit = pwdata[20:0];
        REG_ERR_THR:   cfg_nxt.err_thr = pwdata[15:0];
        REG_SHORT_THR: cfg_nxt.short_thr = pwdata[15:0];
        REG_LONG_THR:  cfg_nxt.long_thr = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_POS_LIMIT: prdata = 32'(cfg_r.pos_limit);
      REG_VEL_LIMIT: prdata = 32'(cfg_r.vel_limit);
      REG_TRQ_LIMIT: prdata = 32'(cfg_r.trq_limit);
      REG_ERR_THR:   prdata = 32'(cfg_r.err_thr);
      REG_SHORT_THR: prdata = 32'(cfg_r.short_thr);
      REG_LONG_THR:  prdata = 32'(cfg_r.long_thr);
      default:       prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_limit <= POS_LIMIT_RST;
      cfg_r.vel_limit <= VEL_LIMIT_RST;
      cfg_r.trq_limit <= TRQ_LIMIT_RST;
      cfg_r.err_thr <= ERR_THR_RST;
      cfg_r.short_thr <= SHORT_THR_RST;
      cfg_r.long_thr <= LONG_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/mffd_scale.sv @@
// Input register, product stage and rounding-divide stage that unpack a frame
// and map its codes onto signed fixed point. Depends on mffd_pkg.
module mffd_scale
  import mffd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [63:0] in_frame,
  output logic        scl_valid,
  input  logic        scl_stall,
  output scaled_t     scl
);

  logic        s1_v_r, s2_v_r, s3_v_r;
  logic        s1_ld, s2_ld, s3_ld;
  logic        s1_action_r;
  logic [63:0] s1_frame_r;

  logic        s2_action_r;
  logic [3:0]  s2_id_r, s2_st_r;
  logic [7:0]  s2_mos_r, s2_coil_r;
  logic [34:0] s2_pprod_r;
  logic [32:0] s2_vprod_r, s2_tprod_r;

  scaled_t     s3_r;
  scaled_t     s3_nxt;
  logic [21:0] pos_q, vel_q, trq_q;
  logic [21:0] pos_d;

  assign s3_ld = !s3_v_r || !scl_stall;
  assign s2_ld = !s2_v_r || s3_ld;
  assign s1_ld = !s1_v_r || s2_ld;
  assign in_stall = !s1_ld;
  assign scl_valid = s3_v_r;
  assign scl = s3_r;

  always_comb begin
    pos_q = div_code(s2_pprod_r, POS_CODE_BITS);
    vel_q = div_code(35'(s2_vprod_r), VT_CODE_BITS);
    trq_q = div_code(35'(s2_tprod_r), VT_CODE_BITS);
    pos_d = pos_q - 22'(cfg.pos_limit);
    s3_nxt.action = s2_action_r;
    s3_nxt.motor_id = s2_id_r;
    s3_nxt.motor_state = s2_st_r;
    s3_nxt.position = pos_d[19:0];
    s3_nxt.velocity = vel_q - 22'(cfg.vel_limit);
    s3_nxt.torque = trq_q - 22'(cfg.trq_limit);
    s3_nxt.mos_temperature = s2_mos_r;
    s3_nxt.coil_temperature = s2_coil_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_ld) s1_v_r <= in_valid;
      if (s2_ld) s2_v_r <= s1_v_r;
      if (s3_ld) s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ld) begin
      s1_action_r <= in_action;
      s1_frame_r <= in_frame;
    end
    if (s2_ld) begin
      s2_action_r <= s1_action_r;
      s2_st_r <= s1_frame_r[63:60];
      s2_id_r <= s1_frame_r[59:56];
      s2_pprod_r <= 35'(s1_frame_r[55:40]) * 35'(cfg.pos_limit);
      s2_vprod_r <= 33'(s1_frame_r[39:28]) * 33'(cfg.vel_limit);
      s2_tprod_r <= 33'(s1_frame_r[27:16]) * 33'(cfg.trq_limit);
      s2_mos_r <= s1_frame_r[15:8];
      s2_coil_r <= s1_frame_r[7:0];
    end
    if (s3_ld) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

@@ rtl/mffd_track.sv @@
// Turn tracking and motor state supervision, one frame per
// cycle while ob_free is high. Depends on mffd_pkg.
module mffd_track
  import mffd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    scl_valid,
  output logic    scl_stall,
  input  scaled_t scl,
  input  logic    ob_free,
  output logic    rec_load,
  output rec_t    rec
);

  logic signed [19:0] prev_pos_r, prev_pos_nxt;
  logic [31:0]        turns_r, turns_nxt;
  logic [48:0]        turns_q_r, turns_q_nxt;
  logic [16:0]        dis_cnt_r, dis_cnt_nxt;
  logic [16:0]        err_cnt_r, err_cnt_nxt;
  logic               err_flag_r, err_flag_nxt;
  logic               fire;
  logic signed [20:0] delta;
  logic               flag_mid;
  logic               en_cmd, clr_cmd;

  assign scl_stall = !(scl.action || ob_free);
  assign fire = scl_valid && !scl_stall;
  assign rec_load = fire && !scl.action;

  always_comb begin
    prev_pos_nxt = prev_pos_r;
    turns_nxt = turns_r;
    turns_q_nxt = turns_q_r;
    dis_cnt_nxt = dis_cnt_r;
    err_cnt_nxt = err_cnt_r;
    err_flag_nxt = err_flag_r;
    en_cmd = 1'b0;
    clr_cmd = 1'b0;
    delta = {scl.position[19], scl.position} - {prev_pos_r[19], prev_pos_r};
    flag_mid = err_flag_r;

    if (scl.action) begin
      turns_nxt = 32'd0;
      turns_q_nxt = 49'd0;
    end else begin
      prev_pos_nxt = scl.position;
      if (delta < -HALF_TURN) begin
        turns_nxt = turns_r + 32'd1;
        turns_q_nxt = (turns_r == TURNS_POS_MAX) ? TURN_Q_MIN : turns_q_r + FULL_TURN;
      end else if (delta > HALF_TURN) begin
        turns_nxt = turns_r - 32'd1;
        turns_q_nxt = (turns_r == TURNS_NEG_MIN) ? TURN_Q_MAX : turns_q_r - FULL_TURN;
      end

      if (scl.motor_state == 4'd1) begin
        dis_cnt_nxt = 17'd0;
        err_cnt_nxt = 17'd0;
        flag_mid = 1'b0;
      end else if (scl.motor_state == 4'd0) begin
        dis_cnt_nxt = (dis_cnt_r == CNT_MAX) ? dis_cnt_r : dis_cnt_r + 17'd1;
        err_cnt_nxt = 17'd0;
      end else begin
        err_cnt_nxt = (err_cnt_r == CNT_MAX) ? err_cnt_r : err_cnt_r + 17'd1;
        dis_cnt_nxt = 17'd0;
      end

      en_cmd = (dis_cnt_nxt > 17'(cfg.short_thr) && !flag_mid) ||
               (dis_cnt_nxt > 17'(cfg.long_thr) && flag_mid);
      if (en_cmd) dis_cnt_nxt = 17'd0;
      clr_cmd = err_cnt_nxt > 17'(cfg.err_thr);
      err_flag_nxt = flag_mid;
      if (clr_cmd) begin
        err_flag_nxt = 1'b1;
        err_cnt_nxt = 17'd0;
      end
    end

    rec.motor_id = scl.motor_id;
    rec.motor_state = scl.motor_state;
    rec.position = scl.position;
    rec.velocity = scl.velocity;
    rec.torque = scl.torque;
    rec.mos_temperature = scl.mos_temperature;
    rec.coil_temperature = scl.coil_temperature;
    rec.turn_count = turns_nxt;
    rec.multiturn_position = {{29{scl.position[19]}}, scl.position} + turns_q_nxt;
    rec.error_latched = err_flag_nxt;
    rec.cmd_enable = en_cmd;
    rec.cmd_clear = clr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pos_r <= 20'sd0;
      turns_r <= 32'd0;
      turns_q_r <= 49'd0;
      dis_cnt_r <= 17'd0;
      err_cnt_r <= 17'd0;
      err_flag_r <= 1'b0;
    end else if (fire) begin
      prev_pos_r <= prev_pos_nxt;
      turns_r <= turns_nxt;
      turns_q_r <= turns_q_nxt;
      dis_cnt_r <= dis_cnt_nxt;
      err_cnt_r <= err_cnt_nxt;
      err_flag_r <= err_flag_nxt;
    end
  end

endmodule

@@ rtl/mffd_out_buf.sv @@
// Result register that hands out the measurement word and any command words
// of one frame in order. Depends on mffd_pkg.
module mffd_out_buf
  import mffd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rec_load,
  input  rec_t               rec,
  output logic               ob_free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic [3:0]         out_motor_id,
  output logic [3:0]         out_motor_state,
  output logic signed [19:0] out_position,
  output logic signed [21:0] out_velocity,
  output logic signed [21:0] out_torque,
  output logic [7:0]         out_mos_temperature,
  output logic [7:0]         out_coil_temperature,
  output logic signed [31:0] out_turn_count,
  output logic signed [48:0] out_multiturn_position,
  output logic               out_error_latched,
  output logic               out_last
);

  // One pending bit per word kind, sent lowest first.
  logic [3:0] pend_r, pend_nxt;
  rec_t       rec_r;
  logic       out_acc;
  logic       meas;
  kind_t      kind;

  assign out_valid = |pend_r;
  assign out_acc = out_valid && !out_stall;
  assign out_last = (pend_r & (pend_r - 4'd1)) == 4'd0;
  assign ob_free = !out_valid || (out_acc && out_last);
  assign meas = pend_r[0];

  always_comb begin
    if (pend_r[0]) begin
      kind = KIND_MEAS;
    end else if (pend_r[1]) begin
      kind = KIND_ENABLE;
    end else if (pend_r[2]) begin
      kind = KIND_CLEAR;
    end else begin
      kind = KIND_DISABLE;
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (rec_load) begin
      pend_nxt = {rec.cmd_clear, rec.cmd_clear, rec.cmd_enable, 1'b1};
    end else if (out_acc) begin
      pend_nxt = pend_r & (pend_r - 4'd1);
    end
  end

  assign out_kind = kind;
  assign out_motor_id = rec_r.motor_id;
  assign out_error_latched = rec_r.error_latched;
  assign out_motor_state = meas ? rec_r.motor_state : 4'd0;
  assign out_position = meas ? rec_r.position : 20'sd0;
  assign out_velocity = meas ? rec_r.velocity : 22'sd0;
  assign out_torque = meas ? rec_r.torque : 22'sd0;
  assign out_mos_temperature = meas ? rec_r.mos_temperature : 8'd0;
  assign out_coil_temperature = meas ? rec_r.coil_temperature : 8'd0;
  assign out_turn_count = meas ? rec_r.turn_count : 32'sd0;
  assign out_multiturn_position = meas ? rec_r.multiturn_position : 49'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec;
    end
  end

endmodule

@@ rtl/motor_feedback_frame_decoder_unit.sv @@
// A frame passes the input register, product stage, rounding-divide stage and
// result register before its first word shows on the result ports.
// Throughput: one frame per cycle while frames give only a measurement word and
// out_stall is low; a frame with commands holds the result register until all
// its words go. Speed is set by the result register, one word per unstalled cycle.
// Reset is synchronous and active low: counters, turns, flags and the pipeline
// clear, and the configuration registers return to their defaults.
module motor_feedback_frame_decoder_unit
  import mffd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [63:0]           in_frame,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_motor_id,
  output logic [3:0]            out_motor_state,
  output logic signed [19:0]    out_position,
  output logic signed [21:0]    out_velocity,
  output logic signed [21:0]    out_torque,
  output logic [7:0]            out_mos_temperature,
  output logic [7:0]            out_coil_temperature,
  output logic signed [31:0]    out_turn_count,
  output logic signed [48:0]    out_multiturn_position,
  output logic                  out_error_latched,
  output logic                  out_last,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  scaled_t scl;
  logic    scl_valid;
  logic    scl_stall;
  logic    ob_free;
  logic    rec_load;
  rec_t    rec;

  mffd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mffd_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_action (in_action),
    .in_frame  (in_frame),
    .scl_valid (scl_valid),
    .scl_stall (scl_stall),
    .scl       (scl)
  );

  mffd_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .scl_valid (scl_valid),
    .scl_stall (scl_stall),
    .scl       (scl),
    .ob_free   (ob_free),
    .rec_load  (rec_load),
    .rec       (rec)
  );

  mffd_out_buf u_out_buf (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .rec_load               (rec_load),
    .rec                    (rec),
    .ob_free                (ob_free),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_kind               (out_kind),
    .out_motor_id           (out_motor_id),
    .out_motor_state        (out_motor_state),
    .out_position           (out_position),
    .out_velocity           (out_velocity),
    .out_torque             (out_torque),
    .out_mos_temperature    (out_mos_temperature),
    .out_coil_temperature   (out_coil_temperature),
    .out_turn_count         (out_turn_count),
    .out_multiturn_position (out_multiturn_position),
    .out_error_latched      (out_error_latched),
    .out_last               (out_last)
  );

endmodule

@@ rtl/mffd_checker.sv @@
// Port-level checker for the frame decoder and the bind that attaches it.
// Depends on mffd_pkg and motor_feedback_frame_decoder_unit_defines.svh.
`include "motor_feedback_frame_decoder_unit_defines.svh"

module mffd_checker
  import mffd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_kind,
  input logic signed [19:0]    out_position,
  input logic signed [31:0]    out_turn_count,
  input logic signed [48:0]    out_multiturn_position,
  input logic                  out_error_latched,
  input logic                  out_last
);

  `MFFD_ASSERT_NOW(a_cmd_fields_zero,
    out_valid && out_kind != KIND_MEAS,
    out_position == 20'sd0 && out_turn_count == 32'sd0 && out_multiturn_position == 49'sd0,
    "Command word carries measurement data.")

  `MFFD_ASSERT_NEXT(a_clear_then_disable,
    out_valid && !out_stall && out_kind == KIND_CLEAR,
    out_valid && out_kind == KIND_DISABLE,
    "Clear-error word is not followed by a disable word.")

  `MFFD_ASSERT_NOW(a_error_cmd_latched,
    out_valid && (out_kind == KIND_CLEAR || out_kind == KIND_DISABLE),
    out_error_latched && (out_kind == KIND_DISABLE || !out_last),
    "Error command word without the error flag or ends the frame early.")

  `MFFD_ASSERT_NEXT(a_out_hold,
    out_valid && out_stall,
    out_valid && $stable(out_kind) && $stable(out_multiturn_position),
    "Stalled result word changed.")

endmodule

bind motor_feedback_frame_decoder_unit mffd_checker u_mffd_checker (.*);
